// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bdlr_pkg.sv =====
// Shared constants and types for the button debouncer.
package bdlr_pkg;

  localparam int COUNT_BITS  = 8;
  localparam int THR_BITS    = 8;
  localparam int CMP_BITS    = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
  localparam int NUM_BUTTONS = 6;
  localparam int ADDR_BITS   = 4;

  // Lanes with long press and auto-repeat: up and down
  localparam logic [NUM_BUTTONS-1:0] REPEAT_MASK = 6'b000110;

  localparam logic [THR_BITS-1:0] SHORT_RESET  = 8'd3;
  localparam logic [THR_BITS-1:0] LONG_RESET   = 8'd50;
  localparam logic [THR_BITS-1:0] REPEAT_RESET = 8'd5;

  typedef enum logic [1:0] {
    REG_SHORT  = 2'd0,
    REG_LONG   = 2'd1,
    REG_REPEAT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [THR_BITS-1:0] short_thr;
    logic [THR_BITS-1:0] long_thr;
    logic [THR_BITS-1:0] repeat_thr;
  } thresh_t;

endpackage

// ===== design/button_debounce_long_repeat.sv =====
// Six-button debouncer with long press and auto-repeat: one tick per transfer, one result each.
// A result is registered into out_ev, or into the skid entry while out_ev holds an untaken result.
// Throughput: one tick per cycle while in_stall is low; each lane updates its counter on each accepted tick.
// A two-entry output skid lets ticks keep flowing while one result waits.
// Reset (rst, synchronous): counters and long-press flags clear, thresholds
// return to 3 / 50 / 5, output buffer empties.
`include "assert_macros.svh"

module button_debounce_long_repeat (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           onoff_level,
  input  logic                           up_level,
  input  logic                           down_level,
  input  logic                           set_level,
  input  logic                           option_level,
  input  logic                           enter_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           onoff_event,
  output logic                           up_event,
  output logic                           down_event,
  output logic                           set_event,
  output logic                           option_event,
  output logic                           enter_event,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdlr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  bdlr_pkg::thresh_t                thr;
  logic [bdlr_pkg::NUM_BUTTONS-1:0] levels;
  logic [bdlr_pkg::NUM_BUTTONS-1:0] lane_ev;
  logic [bdlr_pkg::NUM_BUTTONS-1:0] out_ev;
  logic                             in_take;
  logic                             full;

  assign levels  = {enter_level, option_level, set_level, down_level, up_level, onoff_level};
  assign in_take = in_valid && !in_stall;
  assign in_stall = full;

  bdlr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // one lane per button
  for (genvar i = 0; i < bdlr_pkg::NUM_BUTTONS; i++) begin : g_lane
    bdlr_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .step      (in_take),
      .level     (levels[i]),
      .repeat_en (bdlr_pkg::REPEAT_MASK[i]),
      .thr       (thr),
      .ev        (lane_ev[i])
    );
  end

  bdlr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .lane_ev   (lane_ev),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign onoff_event  = out_ev[0];
  assign up_event     = out_ev[1];
  assign down_event   = out_ev[2];
  assign set_event    = out_ev[3];
  assign option_event = out_ev[4];
  assign enter_event  = out_ev[5];

  // skid holds data only behind a full output register
  `ASSERT_CLK_RST(a_skid_behind_out, in_stall |-> out_valid, "skid full with output empty")
  // an accepted tick always leaves a result
  `ASSERT_CLK_RST(a_take_gives_result, (in_valid && !in_stall) |=> out_valid, "tick lost")
  // skid cannot drain while the output is stalled
  `ASSERT_CLK_RST(a_skid_holds, (in_stall && out_stall) |=> in_stall, "skid drained under stall")

endmodule

// ===== design/bdlr_regs.sv =====
// Threshold registers behind the APB-style configuration port.
module bdlr_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdlr_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output bdlr_pkg::thresh_t              thr
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.short_thr  <= bdlr_pkg::SHORT_RESET;
      thr.long_thr   <= bdlr_pkg::LONG_RESET;
      thr.repeat_thr <= bdlr_pkg::REPEAT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        bdlr_pkg::REG_SHORT:  thr.short_thr  <= pwdata[bdlr_pkg::THR_BITS-1:0];
        bdlr_pkg::REG_LONG:   thr.long_thr   <= pwdata[bdlr_pkg::THR_BITS-1:0];
        bdlr_pkg::REG_REPEAT: thr.repeat_thr <= pwdata[bdlr_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bdlr_pkg::REG_SHORT:  prdata[bdlr_pkg::THR_BITS-1:0] = thr.short_thr;
      bdlr_pkg::REG_LONG:   prdata[bdlr_pkg::THR_BITS-1:0] = thr.long_thr;
      bdlr_pkg::REG_REPEAT: prdata[bdlr_pkg::THR_BITS-1:0] = thr.repeat_thr;
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== design/bdlr_lane.sv =====
// One button lane: hold counter, release event, optional long press and repeat.
module bdlr_lane (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              level,
  input  logic              repeat_en,
  input  bdlr_pkg::thresh_t thr,
  output logic              ev
);

  localparam logic [bdlr_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  logic [bdlr_pkg::COUNT_BITS-1:0] count, count_next;
  logic                            held_long, held_long_next;
  logic [bdlr_pkg::COUNT_BITS-1:0] count_inc;
  logic [bdlr_pkg::CMP_BITS-1:0]   inc_x, count_x;
  logic                            pressed;

  assign pressed   = ~level;
  assign count_inc = (count == CNT_MAX) ? count : count + 1'b1;
  assign inc_x     = bdlr_pkg::CMP_BITS'(count_inc);
  assign count_x   = bdlr_pkg::CMP_BITS'(count);

  // next state and event for this tick
  always_comb begin
    count_next     = count_inc;
    held_long_next = held_long;
    ev             = 1'b0;
    if (pressed) begin
      if (repeat_en && held_long) begin
        if (inc_x > bdlr_pkg::CMP_BITS'(thr.repeat_thr)) begin
          ev         = 1'b1;
          count_next = '0;
        end
      end else if (repeat_en && (inc_x > bdlr_pkg::CMP_BITS'(thr.long_thr))) begin
        ev             = 1'b1;
        held_long_next = 1'b1;
        count_next     = '0;
      end
    end else begin
      ev             = count_x > bdlr_pkg::CMP_BITS'(thr.short_thr);
      held_long_next = 1'b0;
      count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      held_long <= 1'b0;
    end else if (step) begin
      count     <= count_next;
      held_long <= held_long_next;
    end
  end

endmodule

// ===== design/bdlr_out.sv =====
// Merges the lane events into one result and buffers it in a two-entry skid.
module bdlr_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_take,
  input  logic [bdlr_pkg::NUM_BUTTONS-1:0] lane_ev,
  output logic                             full,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bdlr_pkg::NUM_BUTTONS-1:0] out_ev
);

  logic                             skid_valid;
  logic [bdlr_pkg::NUM_BUTTONS-1:0] skid_ev;
  logic                             out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) skid_valid <= 1'b0;
    end else if (in_take) begin
      if (out_valid && !out_take) skid_valid <= 1'b1;
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) out_ev <= skid_ev;
    end else if (in_take) begin
      if (!out_valid || out_take) out_ev <= lane_ev;
      else                        skid_ev <= lane_ev;
    end
  end

endmodule
